// ----- sv/apt_pkg.sv -----
// Shared types, constants and the arctangent table for the 2D point transform.
package apt_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int ANG_WIDTH = 16;
	localparam int OUT_WIDTH = 40;
	localparam int Q_INT = 30;
	localparam int MAX_STAGES = 32;

	localparam int DEF_OUT_FRAC_BITS = 8;
	localparam int DEF_CORDIC_STAGES = 16;

	localparam int ANG_FULL = 23040;
	localparam int ANG_HALF = 11520;
	localparam int ANG_QUARTER = 5760;

	localparam int ROT_WIDTH = COORD_WIDTH + 1;
	localparam int MAG_WIDTH = 13;
	localparam int PROD_WIDTH = ROT_WIDTH + Q_INT + 1;
	localparam int DATA_WIDTH = PROD_WIDTH + 1;
	localparam int ZPROD_WIDTH = 48;
	localparam int Z_WIDTH = 33;

	localparam logic [34:0] ANG_MUL = 35'd19190098069;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	typedef enum logic [1:0] {
		FUNC_TRANSLATE = 2'd0,
		FUNC_SCALE     = 2'd1,
		FUNC_ROTATE    = 2'd2,
		FUNC_PASS      = 2'd3
	} func_t;

	typedef struct packed {
		func_t                          func;
		logic signed [COORD_WIDTH-1:0]  x_in;
		logic signed [COORD_WIDTH-1:0]  y_in;
		logic signed [COORD_WIDTH-1:0]  param_a;
		logic signed [COORD_WIDTH-1:0]  param_b;
		logic signed [ANG_WIDTH-1:0]    angle;
	} in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] x_out;
		logic signed [OUT_WIDTH-1:0] y_out;
	} out_t;

	typedef struct packed {
		logic                          rot;
		logic signed [DATA_WIDTH-1:0]  x;
		logic signed [DATA_WIDTH-1:0]  y;
		logic signed [Z_WIDTH-1:0]     z;
	} stage_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] val;
		case (idx)
			5'd0:  val = 32'h3243F6A8;
			5'd1:  val = 32'h1DAC6705;
			5'd2:  val = 32'h0FADBAFC;
			5'd3:  val = 32'h07F56EA6;
			5'd4:  val = 32'h03FEAB76;
			5'd5:  val = 32'h01FFD55B;
			5'd6:  val = 32'h00FFFAAA;
			5'd7:  val = 32'h007FFF55;
			5'd8:  val = 32'h003FFFEA;
			5'd9:  val = 32'h001FFFFD;
			5'd10: val = 32'h000FFFFF;
			5'd11: val = 32'h0007FFFF;
			5'd12: val = 32'h0003FFFF;
			5'd13: val = 32'h0001FFFF;
			5'd14: val = 32'h0000FFFF;
			5'd15: val = 32'h00007FFF;
			5'd16: val = 32'h00003FFF;
			5'd17: val = 32'h00001FFF;
			5'd18: val = 32'h00000FFF;
			5'd19: val = 32'h000007FF;
			5'd20: val = 32'h000003FF;
			5'd21: val = 32'h000001FF;
			5'd22: val = 32'h000000FF;
			5'd23: val = 32'h0000007F;
			5'd24: val = 32'h0000003F;
			5'd25: val = 32'h0000001F;
			5'd26: val = 32'h0000000F;
			5'd27: val = 32'h00000008;
			5'd28: val = 32'h00000004;
			5'd29: val = 32'h00000002;
			5'd30: val = 32'h00000001;
			default: val = 32'h00000000;
		endcase
		return val;
	endfunction

endpackage

// ----- sv/affine_point_transform_2d_top.sv -----
// Top level of the 2D point transform: translate, scale and pipelined CORDIC rotate.
//
// Usage: a point transaction enters on point/point_valid/point_ready and one
// result transaction leaves on result/result_valid/result_ready for every
// point, in the same order. The func field selects translate, scale, rotate
// or pass-through; all results carry OUT_FRAC_BITS fractional bits.
// The pipeline has three front stages for angle folding, the gain and angle
// multiplies and the angle rounding, one register per CORDIC iteration, and
// one output rounding stage.
// Translate and scale travel the same pipeline, so the order never changes.
// Throughput is one transaction per cycle while the output is not stalled; the
// CORDIC iterations are unrolled into one stage each.
// The whole pipeline advances together whenever the output register is empty
// or being taken. When the receiver stalls with a result waiting, every stage
// holds and point_ready drops until the result is taken.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module affine_point_transform_2d_top #(
	parameter int OUT_FRAC_BITS = apt_pkg::DEF_OUT_FRAC_BITS,
	parameter int CORDIC_STAGES = apt_pkg::DEF_CORDIC_STAGES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          point_valid,
	output logic          point_ready,
	input  apt_pkg::in_t  point,
	output logic          result_valid,
	input  logic          result_ready,
	output apt_pkg::out_t result
);

	localparam int NSTG = (CORDIC_STAGES > apt_pkg::MAX_STAGES) ?
		apt_pkg::MAX_STAGES : CORDIC_STAGES;
	localparam int RND_SHIFT = apt_pkg::Q_INT - OUT_FRAC_BITS;
	localparam int RW = apt_pkg::ROT_WIDTH;
	localparam int DW = apt_pkg::DATA_WIDTH;

	logic adv;

	logic signed [RW-1:0]            ang_w;
	logic signed [RW-1:0]            ang_a;
	logic signed [RW-1:0]            ang_b;
	logic signed [RW-1:0]            ang_c;
	logic signed [RW-1:0]            px;
	logic signed [RW-1:0]            py;
	logic signed [RW-1:0]            x_nx;
	logic signed [RW-1:0]            y_nx;
	logic [apt_pkg::MAG_WIDTH-1:0]   mag_nx;

	logic                            valid_s1;
	apt_pkg::func_t                  func_s1;
	logic signed [RW-1:0]            x_s1;
	logic signed [RW-1:0]            y_s1;
	logic signed [apt_pkg::COORD_WIDTH-1:0] pa_s1;
	logic signed [apt_pkg::COORD_WIDTH-1:0] pb_s1;
	logic                            neg_s1;
	logic [apt_pkg::MAG_WIDTH-1:0]   mag_s1;

	logic signed [apt_pkg::PROD_WIDTH-1:0] gx;
	logic signed [apt_pkg::PROD_WIDTH-1:0] gy;
	logic signed [2*apt_pkg::COORD_WIDTH:0] sx;
	logic signed [2*apt_pkg::COORD_WIDTH:0] sy;
	logic [apt_pkg::ZPROD_WIDTH-1:0]  zp;
	logic signed [DW-1:0]             x2_nx;
	logic signed [DW-1:0]             y2_nx;

	logic                             valid_s2;
	logic                             rot_s2;
	logic                             neg_s2;
	logic signed [DW-1:0]             x_s2;
	logic signed [DW-1:0]             y_s2;
	logic [apt_pkg::ZPROD_WIDTH-1:0]  zp_s2;

	logic [apt_pkg::ZPROD_WIDTH-1:0]  zr;
	logic [apt_pkg::Z_WIDTH-1:0]      zm;
	apt_pkg::stage_t                  st3_nx;
	logic                             valid_s3;
	apt_pkg::stage_t                  st_s3;

	logic                             cvalid [0:NSTG];
	apt_pkg::stage_t                  cstage [0:NSTG];

	logic signed [DW-1:0]             rx;
	logic signed [DW-1:0]             ry;
	apt_pkg::out_t                    res_nx;
	logic                             res_valid_q;
	apt_pkg::out_t                    res_q;

	assign adv = !res_valid_q || result_ready;
	assign point_ready = adv;

	// Stage 1: fold the angle into +-90 degrees and prepare the operands.
	always_comb begin
		ang_w = RW'(point.angle);
		ang_a = (ang_w >= RW'(apt_pkg::ANG_HALF)) ? RW'(ang_w - RW'(apt_pkg::ANG_FULL)) : ang_w;
		ang_b = (ang_a < -RW'(apt_pkg::ANG_HALF)) ? RW'(ang_a + RW'(apt_pkg::ANG_FULL)) : ang_a;
		px = RW'(point.x_in);
		py = RW'(point.y_in);
		x_nx = px;
		y_nx = py;
		ang_c = ang_b;
		case (point.func)
			apt_pkg::FUNC_ROTATE: begin
				if (ang_b > RW'(apt_pkg::ANG_QUARTER)) begin
					x_nx = -py;
					y_nx = px;
					ang_c = ang_b - RW'(apt_pkg::ANG_QUARTER);
				end else if (ang_b < -RW'(apt_pkg::ANG_QUARTER)) begin
					x_nx = py;
					y_nx = -px;
					ang_c = ang_b + RW'(apt_pkg::ANG_QUARTER);
				end
			end
			apt_pkg::FUNC_TRANSLATE: begin
				x_nx = px + RW'(point.param_a);
				y_nx = py + RW'(point.param_b);
			end
			default: begin
				x_nx = px;
				y_nx = py;
			end
		endcase
		mag_nx = ang_c[RW-1] ? apt_pkg::MAG_WIDTH'(-ang_c) : apt_pkg::MAG_WIDTH'(ang_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= point_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			res_valid_q <= cvalid[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= point.func;
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			pa_s1 <= point.param_a;
			pb_s1 <= point.param_b;
			neg_s1 <= ang_c[RW-1];
			mag_s1 <= mag_nx;
		end
	end

	// Stage 2: gain and angle-scale multiplies, or the scale product.
	always_comb begin
		gx = x_s1 * apt_pkg::GAIN_Q30;
		gy = y_s1 * apt_pkg::GAIN_Q30;
		sx = x_s1 * pa_s1;
		sy = y_s1 * pb_s1;
		zp = mag_s1 * apt_pkg::ANG_MUL;
		case (func_s1)
			apt_pkg::FUNC_ROTATE: begin
				x2_nx = DW'(gx);
				y2_nx = DW'(gy);
			end
			apt_pkg::FUNC_SCALE: begin
				x2_nx = DW'(sx) <<< OUT_FRAC_BITS;
				y2_nx = DW'(sy) <<< OUT_FRAC_BITS;
			end
			default: begin
				x2_nx = DW'(x_s1) <<< OUT_FRAC_BITS;
				y2_nx = DW'(y_s1) <<< OUT_FRAC_BITS;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rot_s2 <= (func_s1 == apt_pkg::FUNC_ROTATE);
			neg_s2 <= neg_s1;
			x_s2 <= x2_nx;
			y_s2 <= y2_nx;
			zp_s2 <= zp;
		end
	end

	// Stage 3: round the angle to Q30 radians and apply its sign.
	always_comb begin
		zr = (zp_s2 + apt_pkg::ZPROD_WIDTH'(32768)) >> 16;
		zm = apt_pkg::Z_WIDTH'(zr);
		st3_nx.rot = rot_s2;
		st3_nx.x = x_s2;
		st3_nx.y = y_s2;
		st3_nx.z = neg_s2 ? -$signed(zm) : $signed(zm);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s3 <= st3_nx;
		end
	end

	assign cvalid[0] = valid_s3;
	assign cstage[0] = st_s3;

	for (genvar i = 0; i < NSTG; i++) begin : g_cordic
		apt_cordic_stage #(
			.IDX(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.up_valid (cvalid[i]),
			.up       (cstage[i]),
			.dn_valid (cvalid[i+1]),
			.dn       (cstage[i+1])
		);
	end

	// Output stage: round Q30 rotation results; other results pass as they are.
	always_comb begin
		rx = (cstage[NSTG].x + (DW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
		ry = (cstage[NSTG].y + (DW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
		if (cstage[NSTG].rot) begin
			res_nx.x_out = rx[apt_pkg::OUT_WIDTH-1:0];
			res_nx.y_out = ry[apt_pkg::OUT_WIDTH-1:0];
		end else begin
			res_nx.x_out = cstage[NSTG].x[apt_pkg::OUT_WIDTH-1:0];
			res_nx.y_out = cstage[NSTG].y[apt_pkg::OUT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

// ----- sv/apt_cordic_stage.sv -----
// One registered CORDIC micro-rotation stage with a fixed shift amount.
module apt_cordic_stage #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            up_valid,
	input  apt_pkg::stage_t up,
	output logic            dn_valid,
	output apt_pkg::stage_t dn
);

	logic signed [apt_pkg::DATA_WIDTH-1:0] dx;
	logic signed [apt_pkg::DATA_WIDTH-1:0] dy;
	logic signed [apt_pkg::Z_WIDTH-1:0]    atan_z;
	apt_pkg::stage_t                       nxt;
	apt_pkg::stage_t                       stage_s1;
	logic                                  valid_s1;

	always_comb begin
		dx = up.y >>> IDX;
		dy = up.x >>> IDX;
		atan_z = {1'b0, apt_pkg::atan_q30(5'(IDX))};
		nxt = up;
		if (up.rot) begin
			if (!up.z[apt_pkg::Z_WIDTH-1]) begin
				nxt.x = up.x - dx;
				nxt.y = up.y + dy;
				nxt.z = up.z - atan_z;
			end else begin
				nxt.x = up.x + dx;
				nxt.y = up.y - dy;
				nxt.z = up.z + atan_z;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn = stage_s1;

endmodule

// ----- sv/apt_checker.sv -----
// Port-level assertions for the 2D point transform and their bind to the top level.
module apt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          point_valid,
	input logic          point_ready,
	input apt_pkg::in_t  point,
	input logic          result_valid,
	input logic          result_ready,
	input apt_pkg::out_t result
);

	a_point_held: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid && $stable(point))
		else $error("point transaction changed or withdrawn before it was taken");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result transaction dropped before it was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("stalled result changed");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !point_ready)
		else $error("point taken while the pipeline is stalled");

	a_empty_output_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> point_ready)
		else $error("input not ready with an empty output register");

endmodule

bind affine_point_transform_2d_top apt_checker u_apt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point_valid),
	.point_ready  (point_ready),
	.point        (point),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for affine_point_transform_2d_top with a bit-exact transform predictor.
`timescale 1ns / 100ps

module tb_top;
	import apt_pkg::*;

	localparam int FRAC = DEF_OUT_FRAC_BITS;
	localparam int STAGES = DEF_CORDIC_STAGES;
	localparam int PIPE_LATENCY = STAGES + 4;
	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint DEG_TO_RAD_Q46 = 64'sd19190098069;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
	localparam longint ATAN_Q30 [16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
	};

	typedef struct {
		func_t  f;
		int     x;
		int     y;
		int     pa;
		int     pb;
		int     ang;
		bit     typed;
		longint ex;
		longint ey;
	} dir_row_t;

	dir_row_t dir_tab [N_DIRECTED] = '{
		'{FUNC_TRANSLATE, 0, 0, 0, 0, 0, 1'b1, 64'sd0, 64'sd0},
		'{FUNC_TRANSLATE, 32767, 32767, 32767, 32767, 23039, 1'b1,
			64'sd16776704, 64'sd16776704},
		'{FUNC_TRANSLATE, -32768, -32768, -32768, -32768, -23040, 1'b1,
			-64'sd16777216, -64'sd16777216},
		'{FUNC_TRANSLATE, 32767, -32768, -32768, 32767, -1, 1'b1, -64'sd256, -64'sd256},
		'{FUNC_SCALE, 32767, 32767, 32767, 32767, 0, 1'b1,
			64'sd274861129984, 64'sd274861129984},
		'{FUNC_SCALE, -32768, -32768, -32768, -32768, 0, 1'b1,
			64'sd274877906944, 64'sd274877906944},
		'{FUNC_SCALE, -32768, 32767, 32767, -32768, 0, 1'b1,
			-64'sd274869518336, -64'sd274869518336},
		'{FUNC_SCALE, 1234, -5, 1, 0, 0, 1'b1, 64'sd315904, 64'sd0},
		'{FUNC_SCALE, -1, -1, -1, 1, 0, 1'b1, 64'sd256, -64'sd256},
		'{FUNC_PASS, -32768, 32767, 100, -100, 5760, 1'b1, -64'sd8388608, 64'sd8388352},
		'{FUNC_PASS, 21845, -21846, -21846, 21845, -5761, 1'b1,
			64'sd5592320, -64'sd5592576},
		'{FUNC_ROTATE, 1000, 0, 0, 0, 0, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 1000, 0, 0, 0, 5760, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 1000, 0, 0, 0, -5760, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 32767, 32767, -1, -1, 5761, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, -32768, -32768, 0, 0, 5761, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 32767, -32768, 0, 0, -5761, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, -32768, 32767, 0, 0, 11519, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, -32768, -32768, 0, 0, -11520, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 12345, -6789, 0, 0, 23039, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, -12345, 6789, 0, 0, -23040, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 100, 200, 0, 0, 11520, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 100, 200, 0, 0, -11521, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, 5, -7, 0, 0, 1, 1'b0, 64'sd0, 64'sd0},
		'{FUNC_ROTATE, -5, 7, 0, 0, -1, 1'b0, 64'sd0, 64'sd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_ready;
	in_t point = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_t result;

	out_t transformed_q [$];
	out_t want;
	int err_cnt = 0;
	int checked_cnt = 0;
	int cycle_cnt = 0;
	int burst_left = 0;
	int func_cnt [4] = '{0, 0, 0, 0};
	logic [7:0] stall_tick = '0;
	logic [1:0] stall_mode = '0;
	logic [31:0] stall_mask = '1;

	affine_point_transform_2d_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	function automatic out_t transform_point(input in_t p);
		longint x, y, pa, pb, a, t, z, cx, cy, dx, dy, mag, rx, ry;
		out_t r;
		x = $signed(p.x_in);
		y = $signed(p.y_in);
		pa = $signed(p.param_a);
		pb = $signed(p.param_b);
		a = $signed(p.angle);
		rx = x;
		ry = y;
		case (p.func)
			FUNC_TRANSLATE: begin
				rx = x + pa;
				ry = y + pb;
			end
			FUNC_SCALE: begin
				rx = x * pa;
				ry = y * pb;
			end
			default: begin
			end
		endcase
		r.x_out = 40'(rx <<< FRAC);
		r.y_out = 40'(ry <<< FRAC);
		if (p.func == FUNC_ROTATE) begin
			if (a >= ANG_HALF)
				a -= ANG_FULL;
			if (a < -ANG_HALF)
				a += ANG_FULL;
			if (a > ANG_QUARTER) begin
				t = x;
				x = -y;
				y = t;
				a -= ANG_QUARTER;
			end else if (a < -ANG_QUARTER) begin
				t = x;
				x = y;
				y = -t;
				a += ANG_QUARTER;
			end
			mag = (a < 0 ? -a : a) * DEG_TO_RAD_Q46;
			z = (mag + 64'sd32768) >>> 16;
			if (a < 0)
				z = -z;
			cx = x * CORDIC_GAIN_Q30;
			cy = y * CORDIC_GAIN_Q30;
			for (int i = 0; i < STAGES; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (z >= 0) begin
					cx -= dx;
					cy += dy;
					z -= ATAN_Q30[i];
				end else begin
					cx += dx;
					cy -= dy;
					z += ATAN_Q30[i];
				end
			end
			r.x_out = 40'((cx + (64'sd1 <<< (Q_INT - FRAC - 1))) >>> (Q_INT - FRAC));
			r.y_out = 40'((cy + (64'sd1 <<< (Q_INT - FRAC - 1))) >>> (Q_INT - FRAC));
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(int'($urandom_range(0, 32)) - 16);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_angle();
		int base;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: base = 0;
					1: base = ANG_QUARTER;
					2: base = -ANG_QUARTER;
					3: base = ANG_HALF;
					default: base = -ANG_HALF;
				endcase
				return 16'(base + int'($urandom_range(0, 6)) - 3);
			end
			1: return ($urandom_range(0, 1) != 0) ? 16'(-ANG_FULL) : 16'(ANG_FULL - 1);
			default: return 16'(int'($urandom_range(0, 2 * ANG_FULL - 1)) - ANG_FULL);
		endcase
	endfunction

	task automatic send_point(input in_t p, input bit typed, input out_t ex);
		int gap;
		point <= p;
		point_valid <= 1'b1;
		do
			@(posedge clk);
		while (!point_ready);
		transformed_q.push_back(typed ? ex : transform_point(p));
		func_cnt[p.func]++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				point_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick == 8'd0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_mask <= $urandom;
		end
		case (stall_mode)
			2'd0: result_ready <= 1'b1;
			2'd1: result_ready <= stall_mask[stall_tick[4:0]];
			2'd2: result_ready <= (stall_tick[2:0] == 3'd0);
			default: result_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (transformed_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result transaction: x_out %0d y_out %0d",
						result.x_out, result.y_out);
			end else begin
				want = transformed_q.pop_front();
				checked_cnt++;
				if (result.x_out !== want.x_out || result.y_out !== want.y_out) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("result %0d mismatch: x_out exp %0d got %0d, y_out exp %0d got %0d",
							checked_cnt, want.x_out, result.x_out, want.y_out, result.y_out);
				end
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_cnt, transformed_q.size());
		$display("FAIL affine_point_transform_2d_top");
		$finish;
	end

	initial begin
		in_t pt;
		out_t ex;
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			pt.func = dir_tab[i].f;
			pt.x_in = 16'(dir_tab[i].x);
			pt.y_in = 16'(dir_tab[i].y);
			pt.param_a = 16'(dir_tab[i].pa);
			pt.param_b = 16'(dir_tab[i].pb);
			pt.angle = 16'(dir_tab[i].ang);
			ex.x_out = 40'(dir_tab[i].ex);
			ex.y_out = 40'(dir_tab[i].ey);
			send_point(pt, dir_tab[i].typed, ex);
		end

		ex = '0;
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 6)
				pt.func = FUNC_TRANSLATE;
			else if (pick < 12)
				pt.func = FUNC_SCALE;
			else if (pick < 19)
				pt.func = FUNC_ROTATE;
			else
				pt.func = FUNC_PASS;
			pt.x_in = rand_coord();
			pt.y_in = rand_coord();
			pt.param_a = rand_coord();
			pt.param_b = rand_coord();
			pt.angle = rand_angle();
			send_point(pt, 1'b0, ex);
		end
		point_valid <= 1'b0;

		while (transformed_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 10) @(posedge clk);

		$display("Sent %0d point transactions (%0d directed): %0d translate, %0d scale, %0d rotate,",
			N_DIRECTED + N_RANDOM, N_DIRECTED, func_cnt[FUNC_TRANSLATE],
			func_cnt[FUNC_SCALE], func_cnt[FUNC_ROTATE]);
		$display("%0d pass-through; %0d results checked, %0d errors, in %0d cycles.",
			func_cnt[FUNC_PASS], checked_cnt, err_cnt, cycle_cnt);
		if (err_cnt == 0 && transformed_q.size() == 0)
			$display("PASS affine_point_transform_2d_top");
		else
			$display("FAIL affine_point_transform_2d_top");
		$finish;
	end

endmodule
